### design/ptw_pkg.sv
// types and constants shared by the page table walker modules
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  localparam int unsigned VA_W   = 48;
  localparam int unsigned PA_W   = 52;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned WIDX_W = 12;
  localparam int unsigned ROOT_W = 15;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned TAB_W  = 40;              // entry bits 51..12
  localparam int unsigned SLOT_W = TAB_W + IDX_W;   // table word address
  localparam int unsigned OFS4K_W = 12;
  localparam int unsigned OFS2M_W = 21;
  localparam int unsigned HUGE_W  = PA_W - OFS2M_W; // entry bits 51..21

  localparam int unsigned ENT_PRESENT_BIT = 0;
  localparam int unsigned ENT_HUGE_BIT    = 7;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_UNMAP     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAULT = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PA_ZERO  = 2'd0,
    PA_SMALL = 2'd1,
    PA_HUGE  = 2'd2
  } pa_sel_e;

  typedef struct packed {
    logic    load;
    logic    advance;
    logic    mem_rd;
    logic    mem_wr_word;
    logic    mem_wr_clear;
    logic    res_set;
    status_e res_status;
    pa_sel_e res_pa;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] level;
    logic       slot_oob;
    logic       word_oob;
    logic       ent_present;
    logic       ent_huge;
  } dp_stat_t;

endpackage

`default_nettype wire

### design/ptw_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ptw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/ptw_datapath.sv
// walker datapath: operand and walk registers, table memory, result registers
`timescale 1ns / 1ps
`default_nettype none

module ptw_datapath #(
  parameter int unsigned MemWords = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ptw_pkg::ROOT_W-1:0]        cfg_data_i,
  input  wire logic [1:0]                        op_i,
  input  wire logic [ptw_pkg::VA_W-1:0]          virt_addr_i,
  input  wire logic [ptw_pkg::WIDX_W-1:0]        word_index_i,
  input  wire logic [ptw_pkg::DATA_W-1:0]        word_data_i,
  input  wire ptw_pkg::ctrl_cmd_t                cmd_i,
  output ptw_pkg::dp_stat_t                      stat_o,
  output logic      [ptw_pkg::PA_W-1:0]          phys_addr_o,
  output logic                                   huge_page_o,
  output logic      [1:0]                        status_o
);

  import ptw_pkg::*;

  localparam int unsigned AddrW = $clog2(MemWords);
  localparam logic [SLOT_W-1:0] MemWordsW = SLOT_W'(MemWords);

  logic [2:0]        root_q;
  op_e               op_q;
  logic [VA_W-1:0]   va_q;
  logic [WIDX_W-1:0] widx_q;
  logic [DATA_W-1:0] wdata_q;
  logic [TAB_W-1:0]  tab_q, tab_d;
  logic [1:0]        level_q, level_d;
  logic [PA_W-1:0]   pa_q, pa_d;
  logic              huge_q;
  status_e           status_q;

  logic [IDX_W-1:0]  idx;
  logic [SLOT_W-1:0] slot;
  logic [AddrW-1:0]  mem_addr;
  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] entry;

  // root register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_data_i[ROOT_W-1:OFS4K_W];
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      va_q    <= virt_addr_i;
      widx_q  <= word_index_i;
      wdata_q <= word_data_i;
    end
  end

  always_comb begin
    tab_d   = tab_q;
    level_d = level_q;
    if (cmd_i.load) begin
      tab_d   = TAB_W'(root_q);
      level_d = LVL_PML4;
    end else if (cmd_i.advance) begin
      tab_d   = entry[PA_W-1:OFS4K_W];
      level_d = level_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_PML4;
    end else begin
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tab_q <= tab_d;
  end

  // table index for the current level
  always_comb begin
    unique case (level_q)
      LVL_PML4: idx = va_q[47:39];
      LVL_PDPT: idx = va_q[38:30];
      LVL_PD:   idx = va_q[29:21];
      LVL_PT:   idx = va_q[20:12];
      default:  idx = '0;
    endcase
  end

  // tables are page aligned, so the entry word is a plain concatenation
  assign slot = {tab_q, idx};

  assign mem_we    = cmd_i.mem_wr_word | cmd_i.mem_wr_clear;
  assign mem_wdata = cmd_i.mem_wr_word ? wdata_q : '0;
  assign mem_addr  = cmd_i.mem_wr_word ? AddrW'(widx_q) : slot[AddrW-1:0];

  ptw_ram #(
    .Width (DATA_W),
    .Depth (MemWords)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (cmd_i.mem_rd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (entry)
  );

  // result registers
  always_comb begin
    unique case (cmd_i.res_pa)
      PA_SMALL: pa_d = {entry[PA_W-1:OFS4K_W], va_q[OFS4K_W-1:0]};
      PA_HUGE:  pa_d = {entry[PA_W-1:OFS2M_W], va_q[OFS2M_W-1:0]};
      default:  pa_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      pa_q     <= pa_d;
      huge_q   <= (cmd_i.res_pa == PA_HUGE);
      status_q <= cmd_i.res_status;
    end
  end

  assign stat_o.op          = op_q;
  assign stat_o.level       = level_q;
  assign stat_o.slot_oob    = (slot >= MemWordsW);
  assign stat_o.word_oob    = (SLOT_W'(widx_q) >= MemWordsW);
  assign stat_o.ent_present = entry[ENT_PRESENT_BIT];
  assign stat_o.ent_huge    = entry[ENT_HUGE_BIT];

  assign phys_addr_o = pa_q;
  assign huge_page_o = huge_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

### design/ptw_ctrl.sv
// walker controller state machine
`timescale 1ns / 1ps
`default_nettype none

module ptw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire ptw_pkg::dp_stat_t stat_i,
  output ptw_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy,
  output logic                   done_o
);

  import ptw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_ADDR     = 5'b00100,
    S_DATA     = 5'b01000,
    S_DONE     = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.op)
          OP_WRITE: begin
            cmd_o.mem_wr_word = !stat_i.word_oob;
            cmd_o.res_set     = 1'b1;
            cmd_o.res_status  = ST_OK;
            cmd_o.res_pa      = PA_ZERO;
            state_d           = S_DONE;
          end
          OP_TRANSLATE, OP_UNMAP: begin
            state_d = S_ADDR;
          end
          default: begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_OK;
            cmd_o.res_pa     = PA_ZERO;
            state_d          = S_DONE;
          end
        endcase
      end
      S_ADDR: begin
        if (stat_i.slot_oob) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_RANGE;
          cmd_o.res_pa     = PA_ZERO;
          state_d          = S_DONE;
        end else if (stat_i.level == LVL_PT && stat_i.op == OP_UNMAP) begin
          cmd_o.mem_wr_clear = 1'b1;
          cmd_o.res_set      = 1'b1;
          cmd_o.res_status   = ST_OK;
          cmd_o.res_pa       = PA_ZERO;
          state_d            = S_DONE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_DATA;
        end
      end
      S_DATA: begin
        priority if (!stat_i.ent_present) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FAULT;
          cmd_o.res_pa     = PA_ZERO;
          state_d          = S_DONE;
        end else if (stat_i.level == LVL_PD && stat_i.ent_huge) begin
          cmd_o.res_set = 1'b1;
          if (stat_i.op == OP_TRANSLATE) begin
            cmd_o.res_status = ST_OK;
            cmd_o.res_pa     = PA_HUGE;
          end else begin
            cmd_o.res_status = ST_FAULT;
            cmd_o.res_pa     = PA_ZERO;
          end
          state_d = S_DONE;
        end else if (stat_i.level == LVL_PT) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_pa     = PA_SMALL;
          state_d          = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_ADDR;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

### design/page_table_walker.sv
// page table walker top level
//
//   channel   signals                                          direction  transfer when
//   command   start, op_i, virt_addr_i, word_index_i,           in         start & !busy
//             word_data_i
//   result    done_o, phys_addr_o, huge_page_o, status_o        out        done_o
//   config    cfg_valid_i, cfg_data_i, cfg_ready_o              in         cfg_valid_i & cfg_ready_o
//
// one command at a time; busy stays high until the result strobe has gone by
// a table word write or op 3 passes through S_DISPATCH to the result strobe in S_DONE
// a walk uses the single table memory port, per level S_ADDR (address check and read)
// then S_DATA (entry check); an unmap clears its leaf entry in S_ADDR
// reset clears the controller and the root register; table memory is not cleared
// the result strobe lasts one cycle and cannot be held off
`timescale 1ns / 1ps
`default_nettype none

module page_table_walker #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  op_i,
  input  wire logic [ptw_pkg::VA_W-1:0]    virt_addr_i,
  input  wire logic [ptw_pkg::WIDX_W-1:0]  word_index_i,
  input  wire logic [ptw_pkg::DATA_W-1:0]  word_data_i,
  output logic                             done_o,
  output logic      [ptw_pkg::PA_W-1:0]    phys_addr_o,
  output logic                             huge_page_o,
  output logic      [1:0]                  status_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ptw_pkg::ROOT_W-1:0]  cfg_data_i
);

  import ptw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  ptw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  ptw_datapath #(
    .MemWords (MEM_WORDS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .virt_addr_i  (virt_addr_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .phys_addr_o  (phys_addr_o),
    .huge_page_o  (huge_page_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// testbench for the page table walker: planned table writes, walks and unmaps checked against a predictor
`timescale 1ns / 1ps

module tb;
  import ptw_pkg::*;

  localparam int unsigned MEM_WORDS    = 4096;
  localparam int unsigned RAND_ITEMS   = 1750;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef enum logic [1:0] {
    IT_CMD   = 2'd0,
    IT_CFG   = 2'd1,
    IT_DRAIN = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e          kind;
    op_e                 op;
    logic [VA_W-1:0]     va;
    logic [WIDX_W-1:0]   widx;
    logic [DATA_W-1:0]   wdata;
    logic [ROOT_W-1:0]   root;
    logic                gap_ok;
  } walk_item_t;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic            huge;
    status_e         status;
  } xlat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          op_i = OP_WRITE;
  logic [VA_W-1:0]     virt_addr_i = '0;
  logic [WIDX_W-1:0]   word_index_i = '0;
  logic [DATA_W-1:0]   word_data_i = '0;
  logic                done_o;
  logic [PA_W-1:0]     phys_addr_o;
  logic                huge_page_o;
  logic [1:0]          status_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [ROOT_W-1:0]   cfg_data_i = '0;

  page_table_walker #(.MEM_WORDS(MEM_WORDS)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .virt_addr_i  (virt_addr_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .done_o       (done_o),
    .phys_addr_o  (phys_addr_o),
    .huge_page_o  (huge_page_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // table images: one follows the plan, one follows accepted transfers
  logic [DATA_W-1:0] plan_mem   [MEM_WORDS];
  logic [DATA_W-1:0] mirror_mem [MEM_WORDS];
  bit                was_written [MEM_WORDS];

  walk_item_t        cmd_q[$];
  xlat_t             xlat_exp_q[$];
  logic [VA_W-1:0]   recent_va[$];
  logic [ROOT_W-1:0] plan_root = '0;
  logic [ROOT_W-1:0] mirror_root = '0;
  bit                idle_on = 1'b1;
  int unsigned       planned = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;

  function automatic logic [DATA_W-1:0] tbl_rd(bit plan, logic [WIDX_W-1:0] w);
    return plan ? plan_mem[w] : mirror_mem[w];
  endfunction

  function automatic void tbl_wr(bit plan, logic [WIDX_W-1:0] w, logic [DATA_W-1:0] d);
    if (plan) plan_mem[w] = d;
    else mirror_mem[w] = d;
    was_written[w] = 1'b1;
  endfunction

  // returns 0 when the walk would read a word never written
  function automatic bit resolve_walk(input bit plan, input op_e op, input logic [VA_W-1:0] va,
                                      input logic [WIDX_W-1:0] widx,
                                      input logic [DATA_W-1:0] wdata,
                                      input logic [ROOT_W-1:0] root, output xlat_t res);
    logic [63:0]     tab;
    logic [63:0]     slot;
    logic [63:0]     ent;
    logic [IDX_W-1:0] idx;
    bit              fin;
    bit              legal;
    res = '0;
    res.status = ST_OK;
    legal = 1'b1;
    fin = 1'b0;
    tab = {49'd0, root[14:12], 12'd0};
    case (op)
      OP_WRITE: begin
        if (widx < MEM_WORDS) tbl_wr(plan, widx, wdata);
      end
      OP_TRANSLATE, OP_UNMAP: begin
        for (int lvl = 0; lvl < 4; lvl++) begin
          if (!fin) begin
            idx = va[39 - 9 * lvl +: 9];
            slot = (tab >> 3) + idx;
            if (slot >= MEM_WORDS) begin
              res.status = ST_RANGE;
              fin = 1'b1;
            end else if (lvl == 3 && op == OP_UNMAP) begin
              tbl_wr(plan, slot[WIDX_W-1:0], '0);
              fin = 1'b1;
            end else if (!was_written[slot[WIDX_W-1:0]]) begin
              legal = 1'b0;
              fin = 1'b1;
            end else begin
              ent = tbl_rd(plan, slot[WIDX_W-1:0]);
              if (!ent[ENT_PRESENT_BIT]) begin
                res.status = ST_FAULT;
                fin = 1'b1;
              end else if (lvl == 2 && ent[ENT_HUGE_BIT]) begin
                if (op == OP_TRANSLATE) begin
                  res.pa = {ent[51:21], va[20:0]};
                  res.huge = 1'b1;
                end else begin
                  res.status = ST_FAULT;
                end
                fin = 1'b1;
              end else if (lvl == 3) begin
                res.pa = {ent[51:12], va[11:0]};
                fin = 1'b1;
              end else begin
                tab = {12'd0, ent[51:12], 12'd0};
              end
            end
          end
        end
      end
      default: ;
    endcase
    return legal;
  endfunction

  function automatic logic [DATA_W-1:0] ptr_entry(logic [39:0] page);
    return {12'd0, page, 11'd0, 1'b1};
  endfunction

  task automatic plan_cmd(op_e op, logic [VA_W-1:0] va, logic [WIDX_W-1:0] widx,
                          logic [DATA_W-1:0] wdata);
    xlat_t      unused;
    walk_item_t it;
    if (resolve_walk(1'b1, op, va, widx, wdata, plan_root, unused)) begin
      it = '0;
      it.kind = IT_CMD;
      it.op = op;
      it.va = va;
      it.widx = widx;
      it.wdata = wdata;
      it.gap_ok = idle_on;
      cmd_q.push_back(it);
      if (op != OP_NONE) planned++;
    end
  endtask

  task automatic plan_marker(item_kind_e kind, logic [ROOT_W-1:0] root);
    walk_item_t it;
    it = '0;
    it.kind = kind;
    it.op = OP_NONE;
    it.root = root;
    cmd_q.push_back(it);
    if (kind == IT_CFG) plan_root = root;
  endtask

  task automatic plan_access(logic [VA_W-1:0] va);
    logic [VA_W-1:0] v;
    v = va;
    v[11:0] = 12'($urandom);
    if ($urandom_range(0, 3) == 0) v[20:12] = 9'($urandom);
    if ($urandom_range(0, 7) == 0) v[29:21] = 9'($urandom);
    plan_cmd(($urandom_range(0, 3) == 0) ? OP_UNMAP : OP_TRANSLATE, v, 12'($urandom),
             {$urandom, $urandom});
  endtask

  // one walkable path with random entry content, then accesses through it
  task automatic plan_path();
    logic [VA_W-1:0]   va;
    logic [39:0]       tab_page;
    logic [39:0]       nxt;
    logic [DATA_W-1:0] ent;
    int                depth;
    int                n;
    va = 48'({$urandom, $urandom});
    tab_page = 40'(plan_root[14:12]);
    depth = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 4;
    for (int lvl = 0; lvl < depth; lvl++) begin
      if (tab_page < 8) begin
        if ($urandom_range(0, 19) == 0) nxt = 40'({$urandom, $urandom});
        else nxt = 40'($urandom_range(0, 7));
        ent = {$urandom, $urandom};
        ent[51:12] = nxt;
        ent[ENT_PRESENT_BIT] = ($urandom_range(0, 9) != 0);
        if (lvl == 2) ent[ENT_HUGE_BIT] = ($urandom_range(0, 3) == 0);
        plan_cmd(OP_WRITE, 48'({$urandom, $urandom}), {tab_page[2:0], va[39 - 9 * lvl +: 9]},
                 ent);
        tab_page = nxt;
      end
    end
    recent_va.push_back(va);
    if (recent_va.size() > 16) va = recent_va.pop_front();
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) plan_access(recent_va[recent_va.size() - 1]);
  endtask

  task automatic plan_directed();
    plan_cmd(OP_WRITE, '0, 12'd0, ptr_entry(40'd1));
    plan_cmd(OP_WRITE, '0, 12'd512, ptr_entry(40'd2));
    plan_cmd(OP_WRITE, '0, 12'd1024, ptr_entry(40'd3));
    plan_cmd(OP_WRITE, '0, 12'd1536, '1);
    plan_cmd(OP_TRANSLATE, 48'h0, '0, '0);
    plan_cmd(OP_WRITE, '1, 12'd511, '0);
    plan_cmd(OP_TRANSLATE, '1, '0, '0);
    plan_cmd(OP_WRITE, '0, 12'd511, ptr_entry(40'd7));
    plan_cmd(OP_WRITE, '0, 12'd4095, ptr_entry(40'd7));
    plan_cmd(OP_TRANSLATE, '1, '1, '1);
    // huge page at the directory level, then a refused unmap of it
    plan_cmd(OP_WRITE, '0, 12'd1025, 64'h000F_FFFF_FFE0_0081);
    plan_cmd(OP_TRANSLATE, 48'h00_0000_3F_FFFF, '0, '0);
    plan_cmd(OP_UNMAP, 48'h00_0000_3F_FFFF, '0, '0);
    // table pointers beyond the memory
    plan_cmd(OP_WRITE, '0, 12'd1, ptr_entry(40'h100));
    plan_cmd(OP_TRANSLATE, 48'h0080_0000_0000, '0, '0);
    plan_cmd(OP_WRITE, '0, 12'd1026, 64'h000F_FFFF_FFFF_F001);
    plan_cmd(OP_UNMAP, 48'h0000_0040_0000, '0, '0);
    // not present at directory and leaf level
    plan_cmd(OP_WRITE, '0, 12'd1027, 64'h80);
    plan_cmd(OP_TRANSLATE, 48'h0000_0060_0000, '0, '0);
    plan_cmd(OP_WRITE, '0, 12'd1537, 64'hFFFF_FFFF_FFFF_FFFE);
    plan_cmd(OP_TRANSLATE, 48'h0000_0000_1000, '0, '0);
    plan_cmd(OP_UNMAP, 48'h0, '0, '0);
    plan_cmd(OP_TRANSLATE, 48'h0000_0000_0FFF, '0, '0);
    plan_cmd(OP_NONE, '1, '1, '1);
  endtask

  task automatic plan_random();
    logic [ROOT_W-1:0] root;
    int unsigned       goal;
    int unsigned       sel;
    plan_marker(IT_DRAIN, '0);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 0) root = '1;
      else if (p == N_PHASES - 1) root = '0;
      else root = 15'($urandom);
      plan_marker(IT_CFG, root);
      goal = planned + RAND_ITEMS / N_PHASES;
      while (planned < goal) begin
        if (p == N_PHASES - 1 && planned + QUIET_TAIL > goal) idle_on = 1'b0;
        else idle_on = ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 55) plan_path();
        else if (sel < 75 && recent_va.size() != 0)
          plan_access(recent_va[$urandom_range(0, recent_va.size() - 1)]);
        else if (sel < 85)
          plan_cmd(OP_WRITE, 48'({$urandom, $urandom}), 12'($urandom), {$urandom, $urandom});
        else if (sel < 93)
          plan_cmd(($urandom_range(0, 1) == 0) ? OP_UNMAP : OP_TRANSLATE,
                   48'({$urandom, $urandom}), 12'($urandom), {$urandom, $urandom});
        else if (sel < 97)
          plan_cmd(OP_NONE, 48'({$urandom, $urandom}), 12'($urandom), {$urandom, $urandom});
        else if (idle_on)
          plan_marker(IT_DRAIN, '0);
      end
    end
  endtask

  // driver
  int          in_flight = 0;
  int          flight_now;
  int unsigned gap_left = 0;
  bit          gap_taken = 1'b0;
  walk_item_t  head;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      op_i <= OP_WRITE;
      virt_addr_i <= '0;
      word_index_i <= '0;
      word_data_i <= '0;
      cfg_valid_i <= 1'b0;
      cfg_data_i <= '0;
      in_flight <= 0;
      gap_left <= 0;
      gap_taken <= 1'b0;
    end else begin
      flight_now = in_flight + ((start && !busy) ? 1 : 0) - (done_o ? 1 : 0);
      if (flight_now < 0) flight_now = 0;
      in_flight <= flight_now;
      if ((start && busy) || (cfg_valid_i && !cfg_ready_o)) begin
        // transfer still pending
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (cmd_q[0].gap_ok && !gap_taken && $urandom_range(0, 3) == 0) begin
        gap_left <= $urandom_range(0, 4);
        gap_taken <= 1'b1;
        start <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else begin
        head = cmd_q[0];
        case (head.kind)
          IT_CMD: begin
            head = cmd_q.pop_front();
            start <= 1'b1;
            cfg_valid_i <= 1'b0;
            op_i <= head.op;
            virt_addr_i <= head.va;
            word_index_i <= head.widx;
            word_data_i <= head.wdata;
            gap_taken <= 1'b0;
          end
          IT_CFG: begin
            start <= 1'b0;
            if (flight_now == 0 && !busy) begin
              head = cmd_q.pop_front();
              cfg_valid_i <= 1'b1;
              cfg_data_i <= head.root;
            end else begin
              cfg_valid_i <= 1'b0;
            end
          end
          default: begin
            start <= 1'b0;
            cfg_valid_i <= 1'b0;
            if (flight_now == 0 && !busy) head = cmd_q.pop_front();
          end
        endcase
      end
    end
  end

  // monitor
  xlat_t want;
  bit    unused_ok;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (xlat_exp_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result at %0t: phys_addr %h huge %0d status %0d",
                     $time, phys_addr_o, huge_page_o, status_o);
          mismatches++;
        end else begin
          want = xlat_exp_q.pop_front();
          if (phys_addr_o !== want.pa || huge_page_o !== want.huge ||
              status_o !== want.status) begin
            if (mismatches < 10)
              $display("mismatch at %0t: phys_addr %h/%h huge %0d/%0d status %0d/%0d (exp/got)",
                       $time, want.pa, phys_addr_o, want.huge, huge_page_o,
                       want.status, status_o);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) mirror_root = cfg_data_i;
      if (start && !busy) begin
        unused_ok = resolve_walk(1'b0, op_e'(op_i), virt_addr_i, word_index_i, word_data_i,
                                 mirror_root, want);
        xlat_exp_q.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    plan_directed();
    plan_random();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (cmd_q.size() != 0 || start || cfg_valid_i || xlat_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (xlat_exp_q.size() != 0) begin
      $display("%0d results never arrived", xlat_exp_q.size());
      mismatches += xlat_exp_q.size();
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
